/* rtl/cmd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmd_pkg
// Shared widths, register codes, reset values and the sine table generator
// for the chorus modulated delay.
// ----------------------------------------------------------------------------
package cmd_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int PHASE_W     = 24;
	localparam int BASE_W      = 12;
	localparam int DEPTH_W     = 12;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 24;

	// mod_depth (unsigned 12) times sine (signed 16)
	localparam int PROD_W      = 28;
	// signed delay before clamping, wide enough for buffer depths up to 2**17
	localparam int DLY_W       = 18;

	localparam int BUFFER_DEPTH_DEF = 4096;
	localparam int SINE_ENTRIES_DEF = 1024;

	localparam int FIFO_DEPTH  = 8;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
	localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

	localparam logic [PHASE_W-1:0] PHASE_STEP_RST = PHASE_W'(1398);
	localparam logic [BASE_W-1:0]  BASE_DELAY_RST = BASE_W'(480);
	localparam logic [DEPTH_W-1:0] MOD_DEPTH_RST  = DEPTH_W'(0);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PHASE_STEP = 2'd0,
		CFG_BASE_DELAY = 2'd1,
		CFG_MOD_DEPTH  = 2'd2
	} cfg_idx_t;

	localparam longint Q30 = 64'sd1073741824;
	localparam longint SIN_COEF [6] = '{
		64'sd1686629713, -64'sd693598668, 64'sd85569306,
		-64'sd5026995, 64'sd172272, -64'sd3864
	};

	// one Q1.15 sine entry for a table of 2**aw entries, evaluated at elaboration
	function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int k, input int aw);
		longint q;
		longint f;
		longint x;
		longint x2;
		longint acc;
		longint s;
		longint mag;
		int     quad;
		int     i;
		q    = longint'(k) <<< (32 - aw);
		quad = int'((q >>> 30) & 64'sd3);
		f    = q & (Q30 - 64'sd1);
		x    = quad[0] ? (Q30 - f) : f;
		x2   = (x * x) / Q30;
		acc  = SIN_COEF[5];
		for (i = 4; i >= 0; i--) begin
			acc = SIN_COEF[i] + (acc * x2) / Q30;
		end
		s = (x * acc) / Q30;
		if (s < 0) begin
			s = 0;
		end
		mag = (s * 64'sd32767 + Q30 / 2) / Q30;
		if (mag > 64'sd32767) begin
			mag = 64'sd32767;
		end
		return SAMPLE_W'(quad[1] ? -mag : mag);
	endfunction

endpackage
`default_nettype wire

/* rtl/cmd_sine_rom.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmd_sine_rom
// Full-cycle sine table, Q1.15, with a registered read port.
// ----------------------------------------------------------------------------
module cmd_sine_rom #(
	parameter int SINE_ENTRIES = cmd_pkg::SINE_ENTRIES_DEF
) (
	input  wire logic                                 clk,
	input  wire logic [$clog2(SINE_ENTRIES)-1:0]      addr,
	output logic signed [cmd_pkg::SAMPLE_W-1:0]       data
);

	localparam int ADDR_W = $clog2(SINE_ENTRIES);

	logic signed [cmd_pkg::SAMPLE_W-1:0] rom [SINE_ENTRIES];

	for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_rom
		localparam logic signed [cmd_pkg::SAMPLE_W-1:0] ENTRY =
			cmd_pkg::sine_entry(k, ADDR_W);
		assign rom[k] = ENTRY;
	end

	always_ff @(posedge clk) begin
		data <= rom[addr];
	end

endmodule
`default_nettype wire

/* rtl/cmd_delay_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmd_delay_ram
// Sample history ring, one write port and one registered read port.
// ----------------------------------------------------------------------------
module cmd_delay_ram #(
	parameter int BUFFER_DEPTH = cmd_pkg::BUFFER_DEPTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [$clog2(BUFFER_DEPTH)-1:0]      waddr,
	input  wire logic signed [cmd_pkg::SAMPLE_W-1:0]  wdata,
	input  wire logic [$clog2(BUFFER_DEPTH)-1:0]      raddr,
	output logic signed [cmd_pkg::SAMPLE_W-1:0]       rdata
);

	logic signed [cmd_pkg::SAMPLE_W-1:0] mem [BUFFER_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/cmd_out_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmd_out_fifo
// Small result queue that decouples the pipeline from the output stall.
// ----------------------------------------------------------------------------
module cmd_out_fifo (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 push,
	input  wire logic signed [cmd_pkg::SAMPLE_W-1:0]  push_data,
	input  wire logic                                 pop,
	output logic                                      out_valid,
	output logic signed [cmd_pkg::SAMPLE_W-1:0]       out_data,
	output logic [cmd_pkg::CNT_W-1:0]                 count
);

	logic signed [cmd_pkg::SAMPLE_W-1:0] slot_q [cmd_pkg::FIFO_DEPTH];
	logic [cmd_pkg::FIFO_AW-1:0]         wr_ptr_q;
	logic [cmd_pkg::FIFO_AW-1:0]         rd_ptr_q;
	logic [cmd_pkg::CNT_W-1:0]           count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign out_valid = (count_q != '0);
	assign out_data  = slot_q[rd_ptr_q];
	assign count     = count_q;

	// the credit scheme upstream must never overrun the queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> count_q < cmd_pkg::CNT_W'(cmd_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != cmd_pkg::CNT_W'(cmd_pkg::FIFO_DEPTH) && count_q != '0
		|-> cmd_pkg::FIFO_AW'(wr_ptr_q - rd_ptr_q) == count_q[cmd_pkg::FIFO_AW-1:0])
		else $error("queue pointers disagree with count");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && pop |=> $stable(count_q))
		else $error("simultaneous push and pop changed the count");

endmodule
`default_nettype wire

/* rtl/chorus_modulated_delay.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chorus_modulated_delay
// Chorus: sine LFO modulated delay line on Q1.15 audio, one result per item.
// ----------------------------------------------------------------------------
// Takes one item per clock when the output side keeps up. The sine table is
// read at the accepting edge, then come the depth multiply register, the
// history memory read and the half sum written into the eight-entry result
// queue, after which the result is ready. Input stall rises when the items
// in flight plus queued results reach the queue depth. The history memory
// reads as zero until written, tracked by the write pointer and a wrap flag,
// so there is no clearing pass after reset. Buffer depth and sine table size
// must be powers of two. The user must write configuration only while idle;
// the block itself does not enforce it.
// ----------------------------------------------------------------------------
module chorus_modulated_delay #(
	parameter int BUFFER_DEPTH = cmd_pkg::BUFFER_DEPTH_DEF,
	parameter int SINE_ENTRIES = cmd_pkg::SINE_ENTRIES_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [cmd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [cmd_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [cmd_pkg::SAMPLE_W-1:0]   sample_in,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [cmd_pkg::SAMPLE_W-1:0]        sample_out
);

	localparam int AW  = $clog2(BUFFER_DEPTH);
	localparam int SAW = $clog2(SINE_ENTRIES);
	localparam int SW  = cmd_pkg::SAMPLE_W;
	localparam int PW  = cmd_pkg::PROD_W;
	localparam int DW  = cmd_pkg::DLY_W;
	localparam logic signed [DW-1:0] DLY_MAX = DW'(BUFFER_DEPTH - 1);

	// configuration
	logic [cmd_pkg::PHASE_W-1:0] phase_step_q;
	logic [cmd_pkg::BASE_W-1:0]  base_delay_q;
	logic [cmd_pkg::DEPTH_W-1:0] mod_depth_q;

	// sequencing state
	logic [cmd_pkg::PHASE_W-1:0] phase_q;
	logic [AW-1:0]               wp_q;
	logic                        full_q;
	logic [cmd_pkg::CNT_W-1:0]   occ_q;

	logic accept;
	logic pop;

	// pipeline
	logic                 v_s1, v_s2, v_s3;
	logic signed [SW-1:0] x_s1, x_s2, x_s3;
	logic [AW-1:0]        wp_s1, wp_s2;
	logic                 full_s1, full_s2;
	logic signed [PW-1:0] prod_s2;
	logic                 fwd_s3;
	logic                 ok_s3;

	logic signed [SW-1:0] sine_s1;
	logic signed [SW-1:0] hist_rdata;
	logic [cmd_pkg::CNT_W-1:0] fifo_count;
	logic                 fifo_valid;

	// stage 2 combinational
	logic signed [PW-1:0] prod_adj;
	logic signed [12:0]   swing;
	logic signed [DW-1:0] dly_raw;
	logic signed [DW-1:0] dly_cl;
	logic [AW-1:0]        rd_addr;

	// stage 3 combinational
	logic signed [SW-1:0] delayed;
	logic signed [SW:0]   sum;
	logic signed [SW-1:0] y;

	assign cfg_ready = 1'b1;
	assign in_stall  = (occ_q == cmd_pkg::CNT_W'(cmd_pkg::FIFO_DEPTH));
	assign accept    = in_valid && !in_stall;
	assign pop       = fifo_valid && !out_stall;
	assign out_valid = fifo_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= cmd_pkg::PHASE_STEP_RST;
			base_delay_q <= cmd_pkg::BASE_DELAY_RST;
			mod_depth_q  <= cmd_pkg::MOD_DEPTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cmd_pkg::cfg_idx_t'(cfg_index))
				cmd_pkg::CFG_PHASE_STEP: phase_step_q <= cfg_data;
				cmd_pkg::CFG_BASE_DELAY: base_delay_q <= cfg_data[cmd_pkg::BASE_W-1:0];
				cmd_pkg::CFG_MOD_DEPTH:  mod_depth_q  <= cfg_data[cmd_pkg::DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			wp_q    <= '0;
			full_q  <= 1'b0;
			occ_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_q + phase_step_q;
				wp_q    <= wp_q + 1'b1;
				if (wp_q == AW'(BUFFER_DEPTH - 1)) begin
					full_q <= 1'b1;
				end
			end
			if (accept && !pop) begin
				occ_q <= occ_q + 1'b1;
			end else if (pop && !accept) begin
				occ_q <= occ_q - 1'b1;
			end
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// sine of the phase before the step lands with the item in stage 1
	cmd_sine_rom #(
		.SINE_ENTRIES(SINE_ENTRIES)
	) u_sine (
		.clk  (clk),
		.addr (phase_q[cmd_pkg::PHASE_W-1 -: SAW]),
		.data (sine_s1)
	);

	always_ff @(posedge clk) begin
		x_s1    <= sample_in;
		wp_s1   <= wp_q;
		full_s1 <= full_q;

		prod_s2 <= PW'($signed({1'b0, mod_depth_q}) * sine_s1);
		x_s2    <= x_s1;
		wp_s2   <= wp_s1;
		full_s2 <= full_s1;

		x_s3    <= x_s2;
		fwd_s3  <= (dly_cl == '0);
		ok_s3   <= full_s2 || (rd_addr < wp_s2);
	end

	// divide by 32768 rounding toward zero, then clamp into the buffer
	always_comb begin
		prod_adj = prod_s2 + (prod_s2[PW-1] ? PW'(32767) : PW'(0));
		swing    = prod_adj[PW-1:15];
		dly_raw  = DW'($signed({1'b0, base_delay_q})) + DW'(swing);
		if (dly_raw < 0) begin
			dly_cl = '0;
		end else if (dly_raw > DLY_MAX) begin
			dly_cl = DLY_MAX;
		end else begin
			dly_cl = dly_raw;
		end
		rd_addr = wp_s2 - dly_cl[AW-1:0];
	end

	// write and read in the same cycle; zero delay is forwarded in stage 3
	cmd_delay_ram #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (v_s2),
		.waddr (wp_s2),
		.wdata (x_s2),
		.raddr (rd_addr),
		.rdata (hist_rdata)
	);

	always_comb begin
		if (fwd_s3) begin
			delayed = x_s3;
		end else if (ok_s3) begin
			delayed = hist_rdata;
		end else begin
			delayed = '0;
		end
		sum = (SW+1)'(x_s3) + (SW+1)'(delayed);
		y   = sum[SW:1];
	end

	cmd_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s3),
		.push_data (y),
		.pop       (pop),
		.out_valid (fifo_valid),
		.out_data  (sample_out),
		.count     (fifo_count)
	);

	// every credit is either in the pipeline or in the queue
	a_credit_balance: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == fifo_count + cmd_pkg::CNT_W'(v_s1) + cmd_pkg::CNT_W'(v_s2)
			+ cmd_pkg::CNT_W'(v_s3))
		else $error("credit count out of balance");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= cmd_pkg::CNT_W'(cmd_pkg::FIFO_DEPTH))
		else $error("credit count above queue depth");

	a_wp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && v_s1 |-> wp_s1 == wp_s2 + 1'b1)
		else $error("write pointer skipped between items");

	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(full_q) |-> full_q)
		else $error("buffer wrap flag cleared");

endmodule
`default_nettype wire
